// File: src/mrpt_pkg.sv
// types, codes and helpers shared by the multicast route prefix table
// no dependencies
`timescale 1ns / 1ps

package mrpt_pkg;

    localparam int KEY_W = 64;
    localparam int GRP_W = 32;
    localparam logic [6:0] SG_LEN = 7'd64;
    localparam logic [5:0] GRP_BITS = 6'd32;
    localparam logic [31:0] NO_MATCH = 32'hFFFF_FFFF;

    localparam logic [2:0] FN_INSERT = 3'd0;
    localparam logic [2:0] FN_REMOVE = 3'd1;
    localparam logic [2:0] FN_EXACT = 3'd2;
    localparam logic [2:0] FN_LONGEST = 3'd3;
    localparam logic [2:0] FN_LESS = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_DUP = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DONE
    } bk_state_t;

    // one classified word waiting for the back end
    typedef struct packed {
        logic [2:0] func;
        logic [6:0] len;
        logic [KEY_W-1:0] key;
        logic [GRP_W-1:0] grp;
        logic [31:0] val;
        logic sg_try;
        logic [5:0] start;
    } cmd_t;

    typedef struct packed {
        logic [6:0] len;
        logic [KEY_W-1:0] key;
        logic [31:0] val;
    } slot_t;

    function automatic logic [31:0] grp_mask(input logic [6:0] len);
        logic [5:0] n;
        n = (len > 7'd32) ? GRP_BITS : len[5:0];
        if (n == 6'd0)
            return 32'd0;
        return 32'hFFFF_FFFF << (6'd32 - n);
    endfunction

endpackage

// File: src/mrpt_front.sv
// front end: accepts request words, builds keys and search bounds, queues them
// depends on mrpt_pkg
`timescale 1ns / 1ps

module mrpt_front
    import mrpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [2:0]  func,
    input  logic [31:0] group_addr,
    input  logic [31:0] source_addr,
    input  logic [6:0]  prefix_len,
    input  logic [31:0] entry_value,
    input  logic        pop,
    output logic        cmd_avail,
    output cmd_t        cmd
);

    cmd_t q_reg [2];
    logic wr_ptr_reg, wr_ptr_next;
    logic rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [6:0] adj;
    logic push;
    cmd_t c;

    always_comb
    begin
        // length that the longest-match search runs with
        if (func == FN_LESS)
            adj = (prefix_len == SG_LEN) ? 7'd32 :
                  (prefix_len != 7'd0) ? prefix_len - 7'd1 : 7'd0;
        else
            adj = prefix_len;
        c.func = func;
        c.len = prefix_len;
        c.grp = group_addr;
        c.val = entry_value;
        c.key = {group_addr & grp_mask(prefix_len), source_addr};
        c.sg_try = (adj == SG_LEN);
        c.start = (adj > 7'd32) ? GRP_BITS : adj[5:0];
    end

    assign req_stall = (cnt_reg == 2'd2);
    assign push = req_valid && !req_stall;
    assign cmd_avail = (cnt_reg != 2'd0);
    assign cmd = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= c;
    end

endmodule

// File: src/mrpt_back.sv
// back end: scans the slot memory for one queued word and answers it
// depends on mrpt_pkg
`timescale 1ns / 1ps

module mrpt_back
    import mrpt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_avail,
    input  cmd_t        cmd,
    output logic        pop,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  status,
    output logic        found,
    output logic [31:0] match_value
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    bk_state_t state_reg, state_next;
    cmd_t cmd_reg;
    logic [IW:0] cnt_reg;
    logic rd_v_reg;
    logic [IW-1:0] rd_idx_reg;
    logic rd_valid_reg;
    slot_t rd_data_reg;
    slot_t mem [TABLE_ENTRIES];
    logic slot_valid_reg [TABLE_ENTRIES];

    logic ex_hit_reg;
    logic [IW-1:0] ex_idx_reg;
    logic [31:0] ex_val_reg;
    logic [6:0] best_prio_reg;
    logic [31:0] best_val_reg;
    logic free_found_reg;
    logic [IW-1:0] free_idx_reg;

    logic rsp_valid_reg;
    logic [1:0] status_reg;
    logic found_reg;
    logic [31:0] match_reg;

    logic start_scan, scan_end, finish, out_free;
    logic ex_m, sg_m, g_m;
    logic [6:0] prio;
    logic [1:0] st_next;
    logic fd_next;
    logic [31:0] mv_next;
    logic mem_we, clr;

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign scan_end = (cnt_reg == (IW+1)'(TABLE_ENTRIES)) && !rd_v_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (cmd_avail) state_next = BK_SCAN;
            BK_SCAN: if (scan_end) state_next = BK_DONE;
            BK_DONE: if (out_free) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        start_scan = (state_reg == BK_IDLE) && cmd_avail;
        finish = (state_reg == BK_DONE) && out_free;
        pop = start_scan;
    end

    // per-slot compare on the registered read
    always_comb
    begin
        ex_m = rd_v_reg && rd_valid_reg && rd_data_reg.len == cmd_reg.len
               && rd_data_reg.key == cmd_reg.key;
        sg_m = rd_v_reg && rd_valid_reg && cmd_reg.sg_try && rd_data_reg.len == SG_LEN
               && rd_data_reg.key == {cmd_reg.grp, cmd_reg.key[31:0]};
        g_m = rd_v_reg && rd_valid_reg && rd_data_reg.len <= {1'b0, cmd_reg.start}
              && rd_data_reg.key[31:0] == 32'd0
              && rd_data_reg.key[63:32] == (cmd_reg.grp & grp_mask(rd_data_reg.len));
        prio = sg_m ? 7'd66 : (g_m ? rd_data_reg.len + 7'd1 : 7'd0);
    end

    always_comb
    begin
        st_next = ST_NOT_FOUND;
        fd_next = 1'b0;
        mv_next = NO_MATCH;
        mem_we = 1'b0;
        clr = 1'b0;
        case (cmd_reg.func)
            FN_INSERT:
            begin
                if (ex_hit_reg)
                    st_next = ST_DUP;
                else if (free_found_reg)
                begin
                    st_next = ST_OK;
                    mem_we = finish;
                end
                else
                    st_next = ST_FULL;
            end
            FN_REMOVE:
            begin
                st_next = ST_OK;
                clr = finish && ex_hit_reg;
            end
            FN_EXACT:
            begin
                if (ex_hit_reg)
                begin
                    st_next = ST_OK;
                    fd_next = 1'b1;
                    mv_next = ex_val_reg;
                end
            end
            FN_LONGEST, FN_LESS:
            begin
                if (best_prio_reg != 7'd0)
                begin
                    st_next = ST_OK;
                    fd_next = 1'b1;
                    mv_next = best_val_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            rsp_valid_reg <= 1'b0;
            rd_v_reg <= 1'b0;
            cnt_reg <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
                slot_valid_reg[i] <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
            if (start_scan)
                cnt_reg <= '0;
            else if (state_reg == BK_SCAN && cnt_reg != (IW+1)'(TABLE_ENTRIES))
                cnt_reg <= cnt_reg + 1'b1;
            rd_v_reg <= (state_reg == BK_SCAN) && cnt_reg != (IW+1)'(TABLE_ENTRIES);
            if (mem_we)
                slot_valid_reg[free_idx_reg] <= 1'b1;
            if (clr)
                slot_valid_reg[ex_idx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= cnt_reg[IW-1:0];
        rd_valid_reg <= slot_valid_reg[cnt_reg[IW-1:0]];
        if (start_scan)
        begin
            cmd_reg <= cmd;
            ex_hit_reg <= 1'b0;
            best_prio_reg <= 7'd0;
            free_found_reg <= 1'b0;
        end
        else if (rd_v_reg)
        begin
            // at most one slot per length can match, so the first one is kept
            if (ex_m && !ex_hit_reg)
            begin
                ex_hit_reg <= 1'b1;
                ex_idx_reg <= rd_idx_reg;
                ex_val_reg <= rd_data_reg.val;
            end
            if (prio > best_prio_reg)
            begin
                best_prio_reg <= prio;
                best_val_reg <= rd_data_reg.val;
            end
            if (!rd_valid_reg && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg <= rd_idx_reg;
            end
        end
        if (finish)
        begin
            status_reg <= st_next;
            found_reg <= fd_next;
            match_reg <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[free_idx_reg] <= '{len: cmd_reg.len, key: cmd_reg.key, val: cmd_reg.val};
        rd_data_reg <= mem[cnt_reg[IW-1:0]];
    end

    assign rsp_valid = rsp_valid_reg;
    assign status = status_reg;
    assign found = found_reg;
    assign match_value = match_reg;

endmodule

// File: src/multicast_route_prefix_table.sv
// top level of the multicast route prefix table
// depends on mrpt_pkg, mrpt_front and mrpt_back
//
// request channel (req_valid / req_stall): one word per operation carrying
// func, group_addr, source_addr, prefix_len and entry_value. a word is taken
// on a clock edge with req_valid high and req_stall low. a two-word queue
// sits behind the port, so req_stall rises only when two words are waiting.
// response channel (rsp_valid / rsp_stall): exactly one word per request,
// in request order, with status, found and match_value.
// every operation walks all TABLE_ENTRIES slots of the slot memory through
// its single read port, one slot per cycle; the back end finishes one word
// before it takes the next one from the queue.
// insert writes and remove clears only after the walk ends.
// a finished response sits in an output register; while rsp_stall holds it,
// the next operation still walks the table and then waits for the register,
// further words queue and, once the queue fills, req_stall rises.
// reset clears all slot valid bits at once; the table starts empty and no
// clearing pass is needed.
`timescale 1ns / 1ps

module multicast_route_prefix_table
    import mrpt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [2:0]  func,
    input  logic [31:0] group_addr,
    input  logic [31:0] source_addr,
    input  logic [6:0]  prefix_len,
    input  logic [31:0] entry_value,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  status,
    output logic        found,
    output logic [31:0] match_value
);

    cmd_t cmd;
    logic cmd_avail;
    logic pop;

    mrpt_front u_front (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .func(func), .group_addr(group_addr), .source_addr(source_addr),
        .prefix_len(prefix_len), .entry_value(entry_value),
        .pop(pop), .cmd_avail(cmd_avail), .cmd(cmd)
    );

    mrpt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_avail(cmd_avail), .cmd(cmd), .pop(pop),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .status(status), .found(found), .match_value(match_value)
    );

endmodule

// File: src/mrpt_checker.sv
// port-level checks for the multicast route prefix table, bound to the top
// depends on mrpt_pkg
`timescale 1ns / 1ps

module mrpt_checker
    import mrpt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [1:0]  status,
    input logic        found,
    input logic [31:0] match_value
);

    // a stalled response word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(match_value) && $stable(status))
        else $error("response changed while stalled");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && found |-> status == ST_OK)
        else $error("hit without ok status");

    a_miss_ones: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !found |-> match_value == NO_MATCH)
        else $error("miss with a match value");

endmodule

bind multicast_route_prefix_table mrpt_checker u_mrpt_checker (
    .clk(clk), .rst_n(rst_n), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .found(found), .match_value(match_value)
);

// File: verif/multicast_route_prefix_table_checker.sv
// checker for the multicast route prefix table: watches both channels, keeps its
// own copy of the slot table, predicts each response and compares it
// depends on mrpt_pkg
`timescale 1ns / 1ps

module multicast_route_prefix_table_checker
    import mrpt_pkg::*;
#(
    parameter int SLOTS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  logic [2:0]  func,
    input  logic [31:0] group_addr,
    input  logic [31:0] source_addr,
    input  logic [6:0]  prefix_len,
    input  logic [31:0] entry_value,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  logic [1:0]  status,
    input  logic        found,
    input  logic [31:0] match_value,
    output int          errors,
    output int          pending,
    output int          checked
);

    typedef struct packed {
        logic [1:0]  st;
        logic        hit;
        logic [31:0] val;
    } answer_t;

    answer_t answers_due[$];

    logic        tbl_used [SLOTS];
    logic [6:0]  tbl_len  [SLOTS];
    logic [63:0] tbl_key  [SLOTS];
    logic [31:0] tbl_val  [SLOTS];

    // keep the top min(len,32) bits of the group
    function automatic logic [31:0] group_bits(logic [31:0] g, int len);
        logic [31:0] m;
        int n;
        m = '0;
        n = (len > 32) ? 32 : len;
        for (int i = 0; i < n; i++)
            m[31-i] = 1'b1;
        return g & m;
    endfunction

    function automatic int lookup_slot(logic [6:0] len, logic [63:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (tbl_used[i] && tbl_len[i] == len && tbl_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic int longest_slot(logic [31:0] g, logic [31:0] s, int len);
        int hit;
        int from;
        if (len == 64)
        begin
            hit = lookup_slot(SG_LEN, {g, s});
            if (hit >= 0)
                return hit;
            from = 32;
        end
        else
            from = (len > 32) ? 32 : len;
        for (int m = from; m >= 0; m--)
        begin
            hit = lookup_slot(7'(m), {group_bits(g, m), 32'd0});
            if (hit >= 0)
                return hit;
        end
        return -1;
    endfunction

    function automatic answer_t apply_word(logic [2:0] f, logic [31:0] g, logic [31:0] s,
                                           logic [6:0] len, logic [31:0] v);
        answer_t a;
        logic [63:0] key;
        int hit;
        a = '{st: ST_NOT_FOUND, hit: 1'b0, val: NO_MATCH};
        key = {group_bits(g, len), s};
        hit = -1;
        case (f)
            FN_INSERT:
            begin
                if (lookup_slot(len, key) >= 0)
                    a.st = ST_DUP;
                else
                begin
                    a.st = ST_FULL;
                    for (int i = 0; i < SLOTS; i++)
                        if (!tbl_used[i])
                        begin
                            tbl_used[i] = 1'b1;
                            tbl_len[i] = len;
                            tbl_key[i] = key;
                            tbl_val[i] = v;
                            a.st = ST_OK;
                            break;
                        end
                end
            end
            FN_REMOVE:
            begin
                hit = lookup_slot(len, key);
                if (hit >= 0)
                    tbl_used[hit] = 1'b0;
                hit = -1;
                a.st = ST_OK;
            end
            FN_EXACT:   hit = lookup_slot(len, key);
            FN_LONGEST: hit = longest_slot(g, s, len);
            FN_LESS:    hit = longest_slot(g, s, (len == SG_LEN) ? 32 :
                                                 (len != 0) ? len - 1 : 0);
            default: ;
        endcase
        if (f == FN_EXACT || f == FN_LONGEST || f == FN_LESS)
        begin
            if (hit >= 0)
                a = '{st: ST_OK, hit: 1'b1, val: tbl_val[hit]};
            else
                a.st = ST_NOT_FOUND;
        end
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t exp_a;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                tbl_used[i] = 1'b0;
            answers_due.delete();
            errors = 0;
            pending = 0;
            checked = 0;
        end
        else
        begin
            // responses first: a word taken now cannot answer in the same cycle
            if (rsp_valid && !rsp_stall)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("response word with nothing outstanding");
                    errors++;
                end
                else
                begin
                    exp_a = answers_due.pop_front();
                    checked++;
                    if (status !== exp_a.st)
                    begin
                        $error("status: expected %0d, got %0d", exp_a.st, status);
                        errors++;
                    end
                    if (found !== exp_a.hit)
                    begin
                        $error("found: expected %0d, got %0d", exp_a.hit, found);
                        errors++;
                    end
                    if (match_value !== exp_a.val)
                    begin
                        $error("match_value: expected %h, got %h", exp_a.val, match_value);
                        errors++;
                    end
                end
            end
            if (req_valid && !req_stall)
                answers_due.push_back(apply_word(func, group_addr, source_addr,
                                                 prefix_len, entry_value));
            pending = answers_due.size();
        end
    end

endmodule

// File: verif/multicast_route_prefix_table_tb.sv
// testbench top for the multicast route prefix table: drives request words with
// random gaps and response back-pressure, checking is done by the checker module
// depends on mrpt_pkg, multicast_route_prefix_table and its checker
`timescale 1ns / 1ps

module multicast_route_prefix_table_tb;
    import mrpt_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [2:0]  func = '0;
    logic [31:0] group_addr = '0;
    logic [31:0] source_addr = '0;
    logic [6:0]  prefix_len = '0;
    logic [31:0] entry_value = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [1:0]  status;
    logic        found;
    logic [31:0] match_value;

    int errors;
    int pending;
    int checked;
    int words_sent = 0;
    bit quiet = 0;       // no idling on either side
    bit hold_req = 0;    // ask the receiver for one long hold-off

    logic [31:0] group_pool [8];
    logic [31:0] source_pool [4];
    logic [31:0] filled_grp [$];
    logic [6:0]  filled_len [$];

    always #5 clk = ~clk;

    multicast_route_prefix_table dut (.*);

    multicast_route_prefix_table_checker chk (.*);

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(20, 80);
    endfunction

    // receiver back-pressure
    initial
    begin
        int left;
        left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req <= 1'b0;
                left = 3000;
            end
            if (left > 0)
            begin
                left--;
                rsp_stall <= 1'b1;
            end
            else if (quiet)
                rsp_stall <= 1'b0;
            else
            begin
                rsp_stall <= ($urandom_range(0, 99) < 30);
                if ($urandom_range(0, 99) < 2)
                    left = $urandom_range(20, 200);
            end
        end
    end

    task automatic send_word(logic [2:0] f, logic [31:0] g, logic [31:0] s,
                             logic [6:0] len, logic [31:0] v);
        int gap;
        req_valid <= 1'b1;
        func <= f;
        group_addr <= g;
        source_addr <= s;
        prefix_len <= len;
        entry_value <= v;
        do
            @(negedge clk);
        while (req_stall);
        @(posedge clk);
        words_sent++;
        gap = gap_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] some_value();
        logic [31:0] v;
        v = $urandom;
        if (v == NO_MATCH || $urandom_range(0, 49) == 0)
            v = 32'hFFFF_FFFE;
        return v;
    endfunction

    // mixed traffic over a small pool of keys so lookups hit often
    task automatic send_mixed();
        logic [2:0]  f;
        logic [31:0] g;
        logic [31:0] s;
        logic [6:0]  len;
        int r;
        r = $urandom_range(0, 99);
        f = (r < 3) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        g = group_pool[$urandom_range(0, 7)];
        if ($urandom_range(0, 9) == 0)
            g = $urandom;
        else if ($urandom_range(0, 3) == 0)
            g ^= $urandom_range(0, 255);
        r = $urandom_range(0, 99);
        if (r < 20)
            len = SG_LEN;
        else if (r < 25)
            len = 7'($urandom_range(65, 127));
        else
            len = 7'($urandom_range(0, 32));
        if (len == SG_LEN)
            s = source_pool[$urandom_range(0, 3)];
        else
            s = ($urandom_range(0, 9) == 0) ? $urandom : 32'd0;
        send_word(f, g, s, len, some_value());
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < 8; i++)
            group_pool[i] = {4'he, 28'($urandom)};
        group_pool[0] = 32'hEF01_0100;
        for (int i = 0; i < 4; i++)
            source_pool[i] = $urandom;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every operation, dup, (S,G) fallback, odd lengths
        quiet = 1;
        send_word(FN_EXACT, 32'hEF01_0100, 32'd0, 7'd24, 32'd0);
        send_word(FN_INSERT, 32'hEF01_01FF, 32'd0, 7'd24, 32'd0);
        send_word(FN_INSERT, 32'hEF01_0100, 32'd0, 7'd24, 32'd5);
        send_word(FN_INSERT, 32'hEF01_0100, 32'hC0A8_0001, SG_LEN, 32'hFFFF_FFFE);
        send_word(FN_INSERT, 32'hFFFF_FFFF, 32'd0, 7'd0, 32'd7);
        send_word(FN_INSERT, 32'hFFFF_FFFF, 32'd0, 7'd32, 32'h1234_5678);
        send_word(FN_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127, 32'd9);
        send_word(FN_EXACT, 32'hEF01_0123, 32'd0, 7'd24, 32'd0);
        send_word(FN_LONGEST, 32'hEF01_0100, 32'hC0A8_0001, SG_LEN, 32'd0);
        send_word(FN_LONGEST, 32'hEF01_0177, 32'hC0A8_0002, SG_LEN, 32'd0);
        send_word(FN_LONGEST, 32'hFFFF_FFFF, 32'd0, SG_LEN, 32'd0);
        send_word(FN_LONGEST, 32'h0000_0001, 32'd0, 7'd20, 32'd0);
        send_word(FN_LONGEST, 32'hFFFF_FFFF, 32'd0, 7'd127, 32'd0);
        send_word(FN_EXACT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127, 32'd0);
        send_word(FN_LESS, 32'hEF01_0100, 32'hC0A8_0001, SG_LEN, 32'd0);
        send_word(FN_LESS, 32'hFFFF_FFFF, 32'd0, 7'd32, 32'd0);
        send_word(FN_LESS, 32'hEF01_0100, 32'd0, 7'd25, 32'd0);
        send_word(FN_LESS, 32'hEF01_0100, 32'd0, 7'd0, 32'd0);
        send_word(FN_REMOVE, 32'hEF01_0100, 32'd0, 7'd24, 32'd0);
        send_word(FN_REMOVE, 32'hEF01_0100, 32'd0, 7'd24, 32'd0);
        send_word(FN_EXACT, 32'hEF01_0100, 32'd0, 7'd24, 32'd0);
        send_word(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127, 32'hFFFF_FFFF);
        send_word(3'd6, 32'd0, 32'd0, 7'd0, 32'd0);
        send_word(3'd7, 32'hFFFF_FFFF, 32'd0, 7'd64, 32'd0);
        quiet = 0;

        repeat (450) send_mixed();
        // sender pauses until the table has answered everything
        wait_drained();

        // receiver holds off while the sender keeps offering words
        hold_req <= 1'b1;
        repeat (120) send_mixed();

        // fill past capacity so the table-full answer shows up
        for (int i = 0; i < 300; i++)
        begin
            filled_grp.push_back($urandom);
            filled_len.push_back(7'($urandom_range(0, 32)));
            send_word(FN_INSERT, filled_grp[$], 32'd0, filled_len[$], some_value());
            if (i % 10 == 0)
                send_word(FN_LONGEST, $urandom, 32'd0, 7'd32, 32'd0);
        end
        while (filled_grp.size() > 0)
        begin
            send_word(FN_REMOVE, filled_grp.pop_front(), 32'd0, filled_len.pop_front(), 32'd0);
            if ($urandom_range(0, 9) == 0)
                send_mixed();
        end

        quiet = 1;
        repeat (100) send_mixed();
        quiet = 0;
        repeat (500) send_mixed();
        wait_drained();

        $display("sent %0d request words, %0d responses compared", words_sent, checked);
        $display("covered insert/remove/lookups, duplicate, full table and long stalls");
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: multicast_route_prefix_table.f
src/mrpt_pkg.sv
src/mrpt_front.sv
src/mrpt_back.sv
src/multicast_route_prefix_table.sv
src/mrpt_checker.sv
verif/multicast_route_prefix_table_checker.sv
verif/multicast_route_prefix_table_tb.sv
